@@ rtl/core/vna_pkg.sv @@
// ----------------------------------------------------------------------------
// vna_pkg
// Shared types and constants of the vertex normal averager: item actions,
// datapath operations and the command/status words between control and data.
// ----------------------------------------------------------------------------
package vna_pkg;

    // Item actions
    typedef enum logic [1:0] {
        ACT_LOAD = 2'd0,
        ACT_FACE = 2'd1,
        ACT_READ = 2'd2,
        ACT_NONE = 2'd3
    } t_action;

    // Vertex selects carried in the step field
    localparam logic [1:0] SEL_A   = 2'd0;
    localparam logic [1:0] SEL_B   = 2'd1;
    localparam logic [1:0] SEL_C   = 2'd2;
    localparam logic [1:0] SEL_IDX = 2'd3;

    // Datapath operations, one per cycle
    typedef enum logic [4:0] {
        DP_NOP,
        DP_CLEAR,
        DP_LOAD,
        DP_RD_POS,
        DP_EDGE,
        DP_CROSS,
        DP_ABS,
        DP_NORM_SHIFT,
        DP_FN_ZERO,
        DP_SQ,
        DP_SQRT_INIT,
        DP_SQRT_STEP,
        DP_DIV_FACE,
        DP_DIV_FOLD,
        DP_DIV_STEP,
        DP_FN_STORE,
        DP_RD_NC,
        DP_NC_CAP,
        DP_FOLD_MUL,
        DP_FOLD_STORE,
        DP_WR_NC,
        DP_OUT
    } t_dp_op;

    typedef struct packed {
        t_dp_op      op;
        logic [4:0]  step;
    } t_dp_cmd;

    typedef struct packed {
        logic        clr_last;
        t_action     action;
        logic        item_ok;
        logic        cross_zero;
        logic        norm_ok;
    } t_dp_stat;

    // Arithmetic widths
    localparam int POS_W   = 32;
    localparam int EDGE_W  = 33;
    localparam int PROD_W  = 66;
    localparam int CROSS_W = 68;
    localparam int NRM_W   = 16;
    localparam int CNT_W   = 16;
    localparam int ROOT_W  = 64;
    localparam int LEN_W   = 31;
    localparam int DIV_W   = 48;
    localparam int Q_W     = 16;
    localparam int UNIT_BIT = 29;   // scaled magnitudes land in [2^29, 2^30)
    localparam int FRAC_W  = 14;

    // Step counts
    localparam logic [4:0] POS_LAST   = 5'd2;
    localparam logic [4:0] CROSS_LAST = 5'd6;
    localparam logic [4:0] SQ_LAST    = 5'd3;
    localparam logic [4:0] SQRT_LAST  = 5'd31;
    localparam logic [4:0] DIV_LAST   = 5'd15;
    localparam logic [1:0] COMP_LAST  = 2'd2;

    localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

endpackage

@@ rtl/core/vna_ctrl.sv @@
// ----------------------------------------------------------------------------
// vna_ctrl
// Sequencer of the vertex normal averager: clearing pass, item decode and the
// step-by-step schedule of face normal and running average arithmetic.
// ----------------------------------------------------------------------------
module vna_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  vna_pkg::t_dp_stat i_stat,
    output vna_pkg::t_dp_cmd  o_cmd,
    output logic              o_busy
);
    import vna_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_DECODE, S_LOAD, S_RD, S_OUT,
        S_POS, S_EDGE, S_CROSS, S_ABS, S_NORM, S_SQ, S_SQRT_INIT, S_SQRT,
        S_DIV_INIT, S_DIV, S_FN_STORE,
        S_NC_RD, S_NC_CAP, S_FMUL, S_FDIV_INIT, S_FSTORE, S_NC_WR
    } t_state;

    t_state     r_state, n_state;
    logic [4:0] r_cnt;
    logic [1:0] r_comp;
    logic [1:0] r_corner;
    logic       r_fold;
    logic       r_busy;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:     n_state = i_stat.clr_last ? S_IDLE : S_CLEAR;
            S_IDLE:      n_state = i_start ? S_DECODE : S_IDLE;
            S_DECODE: begin
                unique case (i_stat.action)
                    ACT_LOAD: n_state = i_stat.item_ok ? S_LOAD : S_IDLE;
                    ACT_READ: n_state = i_stat.item_ok ? S_RD : S_OUT;
                    ACT_FACE: n_state = i_stat.item_ok ? S_POS : S_IDLE;
                    ACT_NONE: n_state = S_IDLE;
                endcase
            end
            S_LOAD:      n_state = S_IDLE;
            S_RD:        n_state = S_OUT;
            S_OUT:       n_state = S_IDLE;
            S_POS:       n_state = (r_cnt == POS_LAST) ? S_EDGE : S_POS;
            S_EDGE:      n_state = S_CROSS;
            S_CROSS:     n_state = (r_cnt == CROSS_LAST) ? S_ABS : S_CROSS;
            S_ABS:       n_state = S_NORM;
            S_NORM: begin
                priority if (i_stat.cross_zero) n_state = S_NC_RD;
                else if (i_stat.norm_ok)        n_state = S_SQ;
                else                            n_state = S_NORM;
            end
            S_SQ:        n_state = (r_cnt == SQ_LAST) ? S_SQRT_INIT : S_SQ;
            S_SQRT_INIT: n_state = S_SQRT;
            S_SQRT:      n_state = (r_cnt == SQRT_LAST) ? S_DIV_INIT : S_SQRT;
            S_DIV_INIT:  n_state = S_DIV;
            S_DIV: begin
                if (r_cnt == DIV_LAST) begin
                    n_state = r_fold ? S_FSTORE : S_FN_STORE;
                end
            end
            S_FN_STORE:  n_state = (r_comp == COMP_LAST) ? S_NC_RD : S_DIV_INIT;
            S_NC_RD:     n_state = S_NC_CAP;
            S_NC_CAP:    n_state = S_FMUL;
            S_FMUL:      n_state = S_FDIV_INIT;
            S_FDIV_INIT: n_state = S_DIV;
            S_FSTORE:    n_state = (r_comp == COMP_LAST) ? S_NC_WR : S_FMUL;
            S_NC_WR:     n_state = (r_corner == COMP_LAST) ? S_IDLE : S_NC_RD;
            default:     n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_busy   <= 1'b1;
            r_cnt    <= '0;
            r_comp   <= '0;
            r_corner <= '0;
            r_fold   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
            r_cnt   <= (n_state == r_state) ? r_cnt + 5'd1 : 5'd0;
            unique case (r_state)
                S_DECODE: begin
                    r_corner <= '0;
                    r_fold   <= 1'b0;
                end
                S_NORM: begin
                    if (i_stat.cross_zero) r_fold <= 1'b1;
                end
                S_SQRT_INIT: r_comp <= '0;
                S_FN_STORE: begin
                    if (r_comp == COMP_LAST) begin
                        r_comp <= '0;
                        r_fold <= 1'b1;
                    end else begin
                        r_comp <= r_comp + 2'd1;
                    end
                end
                S_NC_CAP: r_comp <= '0;
                S_FSTORE: begin
                    if (r_comp != COMP_LAST) r_comp <= r_comp + 2'd1;
                end
                S_NC_WR: r_corner <= r_corner + 2'd1;
                default: ;
            endcase
        end
    end

    always_comb begin
        o_cmd.op   = DP_NOP;
        o_cmd.step = '0;
        unique case (r_state)
            S_CLEAR:     o_cmd.op = DP_CLEAR;
            S_LOAD:      o_cmd.op = DP_LOAD;
            S_RD: begin
                o_cmd.op   = DP_RD_NC;
                o_cmd.step = 5'(SEL_IDX);
            end
            S_OUT:       o_cmd.op = DP_OUT;
            S_POS: begin
                o_cmd.op   = DP_RD_POS;
                o_cmd.step = r_cnt;
            end
            S_EDGE:      o_cmd.op = DP_EDGE;
            S_CROSS: begin
                o_cmd.op   = DP_CROSS;
                o_cmd.step = r_cnt;
            end
            S_ABS:       o_cmd.op = DP_ABS;
            S_NORM: begin
                priority if (i_stat.cross_zero) o_cmd.op = DP_FN_ZERO;
                else if (i_stat.norm_ok)        o_cmd.op = DP_NOP;
                else                            o_cmd.op = DP_NORM_SHIFT;
            end
            S_SQ: begin
                o_cmd.op   = DP_SQ;
                o_cmd.step = r_cnt;
            end
            S_SQRT_INIT: o_cmd.op = DP_SQRT_INIT;
            S_SQRT:      o_cmd.op = DP_SQRT_STEP;
            S_DIV_INIT: begin
                o_cmd.op   = DP_DIV_FACE;
                o_cmd.step = 5'(r_comp);
            end
            S_DIV:       o_cmd.op = DP_DIV_STEP;
            S_FN_STORE: begin
                o_cmd.op   = DP_FN_STORE;
                o_cmd.step = 5'(r_comp);
            end
            S_NC_RD: begin
                o_cmd.op   = DP_RD_NC;
                o_cmd.step = 5'(r_corner);
            end
            S_NC_CAP:    o_cmd.op = DP_NC_CAP;
            S_FMUL: begin
                o_cmd.op   = DP_FOLD_MUL;
                o_cmd.step = 5'(r_comp);
            end
            S_FDIV_INIT: begin
                o_cmd.op   = DP_DIV_FOLD;
                o_cmd.step = 5'(r_comp);
            end
            S_FSTORE: begin
                o_cmd.op   = DP_FOLD_STORE;
                o_cmd.step = 5'(r_comp);
            end
            S_NC_WR: begin
                o_cmd.op   = DP_WR_NC;
                o_cmd.step = 5'(r_corner);
            end
            default: ;
        endcase
    end

    assign o_busy = r_busy;

endmodule

@@ rtl/core/vna_dp.sv @@
// ----------------------------------------------------------------------------
// vna_dp
// Datapath of the vertex normal averager: position and normal/count memories,
// one shared multiplier, normalizing shifter, square root and divider units.
// ----------------------------------------------------------------------------
module vna_dp #(
    parameter int VERTEX_DEPTH = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_take,
    input  logic [1:0]          i_action,
    input  logic [9:0]          i_vertex_index,
    input  logic signed [31:0]  i_pos_x,
    input  logic signed [31:0]  i_pos_y,
    input  logic signed [31:0]  i_pos_z,
    input  logic [9:0]          i_corner_a,
    input  logic [9:0]          i_corner_b,
    input  logic [9:0]          i_corner_c,
    input  vna_pkg::t_dp_cmd    i_cmd,
    output vna_pkg::t_dp_stat   o_stat,
    output logic                o_valid,
    output logic signed [15:0]  o_norm_x,
    output logic signed [15:0]  o_norm_y,
    output logic signed [15:0]  o_norm_z,
    output logic [15:0]         o_face_count
);
    import vna_pkg::*;

    localparam int AW = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
    localparam logic [16:0]   DEPTH_L = 17'(VERTEX_DEPTH);
    localparam logic [AW-1:0] LAST    = AW'(VERTEX_DEPTH - 1);

    // Latched item
    t_action               r_action;
    logic [9:0]            r_idx, r_ca, r_cb, r_cc;
    logic [3*POS_W-1:0]    r_pos_in;

    // Working registers
    logic [3*POS_W-1:0]          r_va, r_vb, r_vc;
    logic signed [EDGE_W-1:0]    r_e1 [3];
    logic signed [EDGE_W-1:0]    r_e2 [3];
    logic signed [PROD_W-1:0]    r_prod;
    logic signed [CROSS_W-1:0]   r_cr [3];
    logic [CROSS_W-1:0]          r_mag [3];
    logic                        r_neg [3];
    logic [ROOT_W-1:0]           r_sum, r_sx, r_sr, r_sbit;
    logic [DIV_W-1:0]            r_dn, r_dd;
    logic [Q_W-1:0]              r_q;
    logic                        r_dneg;
    logic signed [NRM_W-1:0]     r_fn [3];
    logic signed [NRM_W-1:0]     r_old [3];
    logic signed [NRM_W-1:0]     r_new [3];
    logic [CNT_W-1:0]            r_k;
    logic [63:0]                 r_nc_q;
    logic [AW-1:0]               r_clr;
    logic                        r_ovalid;
    logic [63:0]                 r_out;

    logic [3*POS_W-1:0] pos_mem [VERTEX_DEPTH];
    logic [63:0]        nc_mem  [VERTEX_DEPTH];

    t_dp_op                    op;
    logic [1:0]                sel;
    logic [9:0]                sel_idx;
    logic [AW-1:0]             addr;
    logic [CROSS_W-1:0]        c_mag;
    logic                      c_neg;
    logic signed [NRM_W-1:0]   c_fn, c_old;
    logic signed [EDGE_W-1:0]  m_a, m_b;
    logic [CROSS_W-1:0]        mag_or;
    logic [2:0]                acc_p;
    logic signed [CROSS_W-1:0] prod_x;
    logic [ROOT_W-1:0]         sq_t;
    logic [LEN_W-1:0]          len;
    logic signed [33:0]        num;
    logic [33:0]               num_mag;
    logic signed [Q_W-1:0]     qs;

    assign op      = i_cmd.op;
    assign sel     = i_cmd.step[1:0];
    assign len     = r_sr[LEN_W-1:0];
    assign mag_or  = r_mag[0] | r_mag[1] | r_mag[2];
    assign acc_p   = i_cmd.step[2:0] - 3'd1;
    assign prod_x  = {{(CROSS_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
    assign sq_t    = r_sr + r_sbit;
    assign num     = $signed(r_prod[33:0]) + {{(34-NRM_W){c_fn[NRM_W-1]}}, c_fn};
    assign num_mag = num[33] ? 34'(-num) : 34'(num);
    assign qs      = r_dneg ? -$signed(r_q) : $signed(r_q);

    always_comb begin
        unique case (sel)
            SEL_A:   sel_idx = r_ca;
            SEL_B:   sel_idx = r_cb;
            SEL_C:   sel_idx = r_cc;
            SEL_IDX: sel_idx = r_idx;
        endcase
        addr = AW'(sel_idx);
    end

    // Per-component selection; the fourth code selects the third component
    always_comb begin
        unique case (sel)
            2'd0: begin
                c_mag = r_mag[0]; c_neg = r_neg[0]; c_fn = r_fn[0]; c_old = r_old[0];
            end
            2'd1: begin
                c_mag = r_mag[1]; c_neg = r_neg[1]; c_fn = r_fn[1]; c_old = r_old[1];
            end
            default: begin
                c_mag = r_mag[2]; c_neg = r_neg[2]; c_fn = r_fn[2]; c_old = r_old[2];
            end
        endcase
    end

    // Shared multiplier operands
    always_comb begin
        m_a = '0;
        m_b = '0;
        unique case (op)
            DP_CROSS: begin
                unique case (i_cmd.step[2:0])
                    3'd0: begin m_a = r_e1[1]; m_b = r_e2[2]; end
                    3'd1: begin m_a = r_e1[2]; m_b = r_e2[1]; end
                    3'd2: begin m_a = r_e1[2]; m_b = r_e2[0]; end
                    3'd3: begin m_a = r_e1[0]; m_b = r_e2[2]; end
                    3'd4: begin m_a = r_e1[0]; m_b = r_e2[1]; end
                    3'd5: begin m_a = r_e1[1]; m_b = r_e2[0]; end
                    default: ;
                endcase
            end
            DP_SQ: begin
                m_a = $signed({3'b0, c_mag[UNIT_BIT:0]});
                m_b = $signed({3'b0, c_mag[UNIT_BIT:0]});
            end
            DP_FOLD_MUL: begin
                m_a = {{(EDGE_W-NRM_W){c_old[NRM_W-1]}}, c_old};
                m_b = $signed({17'b0, r_k - 16'd1});
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= m_a * m_b;
    end

    // Item latch
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_action <= ACT_NONE;
        end else if (i_take) begin
            r_action <= t_action'(i_action);
        end
        if (i_take) begin
            r_idx    <= i_vertex_index;
            r_ca     <= i_corner_a;
            r_cb     <= i_corner_b;
            r_cc     <= i_corner_c;
            r_pos_in <= {i_pos_z, i_pos_y, i_pos_x};
        end
    end

    // Position memory
    always_ff @(posedge i_clk) begin
        if (op == DP_LOAD) begin
            pos_mem[AW'(r_idx)] <= r_pos_in;
        end
        if (op == DP_RD_POS) begin
            unique case (sel)
                SEL_A:   r_va <= pos_mem[addr];
                SEL_B:   r_vb <= pos_mem[addr];
                default: r_vc <= pos_mem[addr];
            endcase
        end
    end

    // Normal and count memory: {count, z, y, x}
    always_ff @(posedge i_clk) begin
        if (op == DP_CLEAR) begin
            nc_mem[r_clr] <= '0;
        end else if (op == DP_WR_NC) begin
            nc_mem[addr] <= {r_k, r_new[2], r_new[1], r_new[0]};
        end
        if (op == DP_RD_NC) begin
            r_nc_q <= nc_mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (op == DP_CLEAR) begin
            r_clr <= r_clr + AW'(1);
        end
    end

    // Face normal and running average arithmetic
    always_ff @(posedge i_clk) begin
        unique case (op)
            DP_EDGE: begin
                for (int i = 0; i < 3; i++) begin
                    r_e1[i] <= $signed({r_vb[32*i+31], r_vb[32*i +: 32]})
                             - $signed({r_va[32*i+31], r_va[32*i +: 32]});
                    r_e2[i] <= $signed({r_vc[32*i+31], r_vc[32*i +: 32]})
                             - $signed({r_va[32*i+31], r_va[32*i +: 32]});
                end
            end
            DP_CROSS: begin
                if (i_cmd.step[2:0] != 3'd0) begin
                    for (int i = 0; i < 3; i++) begin
                        if (acc_p[2:1] == 2'(i)) begin
                            r_cr[i] <= acc_p[0] ? r_cr[i] - prod_x : prod_x;
                        end
                    end
                end
            end
            DP_ABS: begin
                for (int i = 0; i < 3; i++) begin
                    r_neg[i] <= r_cr[i][CROSS_W-1];
                    r_mag[i] <= r_cr[i][CROSS_W-1] ? CROSS_W'(-r_cr[i])
                                                   : CROSS_W'(r_cr[i]);
                end
            end
            DP_NORM_SHIFT: begin
                for (int i = 0; i < 3; i++) begin
                    if (|mag_or[CROSS_W-1:UNIT_BIT+1]) begin
                        r_mag[i] <= r_mag[i] >> 1;
                    end else begin
                        r_mag[i] <= r_mag[i] << 1;
                    end
                end
            end
            DP_FN_ZERO: begin
                for (int i = 0; i < 3; i++) r_fn[i] <= '0;
            end
            DP_SQ: begin
                if (i_cmd.step[2:0] == 3'd1) begin
                    r_sum <= r_prod[ROOT_W-1:0];
                end else if (i_cmd.step[2:0] != 3'd0) begin
                    r_sum <= r_sum + r_prod[ROOT_W-1:0];
                end
            end
            DP_SQRT_INIT: begin
                r_sx   <= r_sum;
                r_sr   <= '0;
                r_sbit <= 64'h4000_0000_0000_0000;
            end
            DP_SQRT_STEP: begin
                if (r_sx >= sq_t) begin
                    r_sx <= r_sx - sq_t;
                    r_sr <= (r_sr >> 1) + r_sbit;
                end else begin
                    r_sr <= r_sr >> 1;
                end
                r_sbit <= r_sbit >> 2;
            end
            DP_DIV_FACE: begin
                r_dn   <= {4'b0, c_mag[UNIT_BIT:0], {FRAC_W{1'b0}}}
                        + {18'b0, len[LEN_W-1:1]};
                r_dd   <= {2'b0, len, 15'b0};
                r_q    <= '0;
                r_dneg <= c_neg;
            end
            DP_DIV_FOLD: begin
                r_dn   <= {14'b0, num_mag} + {33'b0, r_k[CNT_W-1:1]};
                r_dd   <= {17'b0, r_k, 15'b0};
                r_q    <= '0;
                r_dneg <= num[33];
            end
            DP_DIV_STEP: begin
                if (r_dn >= r_dd) begin
                    r_dn <= r_dn - r_dd;
                    r_q  <= {r_q[Q_W-2:0], 1'b1};
                end else begin
                    r_q  <= {r_q[Q_W-2:0], 1'b0};
                end
                r_dd <= r_dd >> 1;
            end
            DP_FN_STORE: begin
                for (int i = 0; i < 3; i++) begin
                    if (sel == 2'(i)) r_fn[i] <= qs;
                end
            end
            DP_NC_CAP: begin
                r_old[0] <= $signed(r_nc_q[15:0]);
                r_old[1] <= $signed(r_nc_q[31:16]);
                r_old[2] <= $signed(r_nc_q[47:32]);
                r_k      <= (r_nc_q[63:48] == CNT_MAX) ? CNT_MAX
                                                       : r_nc_q[63:48] + 16'd1;
            end
            DP_FOLD_STORE: begin
                for (int i = 0; i < 3; i++) begin
                    if (sel == 2'(i)) r_new[i] <= qs;
                end
            end
            default: ;
        endcase
    end

    // Result word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else begin
            r_ovalid <= (op == DP_OUT);
        end
        if (op == DP_OUT) begin
            r_out <= o_stat.item_ok ? r_nc_q : '0;
        end
    end

    always_comb begin
        o_stat.clr_last   = (r_clr == LAST);
        o_stat.action     = r_action;
        o_stat.cross_zero = (mag_or == '0);
        o_stat.norm_ok    = (mag_or[CROSS_W-1:UNIT_BIT+1] == '0) && mag_or[UNIT_BIT];
        unique case (r_action)
            ACT_LOAD, ACT_READ: o_stat.item_ok = ({7'b0, r_idx} < DEPTH_L);
            ACT_FACE: o_stat.item_ok = ({7'b0, r_ca} < DEPTH_L)
                                    && ({7'b0, r_cb} < DEPTH_L)
                                    && ({7'b0, r_cc} < DEPTH_L);
            ACT_NONE: o_stat.item_ok = 1'b0;
        endcase
    end

    assign o_valid      = r_ovalid;
    assign o_norm_x     = $signed(r_out[15:0]);
    assign o_norm_y     = $signed(r_out[31:16]);
    assign o_norm_z     = $signed(r_out[47:32]);
    assign o_face_count = r_out[63:48];

endmodule

@@ rtl/core/vertex_normal_averager_top.sv @@
// ----------------------------------------------------------------------------
// vertex_normal_averager_top
// Smooth per-vertex normals of a triangle mesh from load, face and read words.
// ----------------------------------------------------------------------------
// Usage:
//   Present a word with start high; it is taken at a rising edge where busy is
//   low. i_action picks load position (i_vertex_index, i_pos_*), add face
//   (i_corner_a/b/c) or read vertex (i_vertex_index).
//   A read returns one result word: o_valid is high for exactly one cycle with
//   o_norm_* and o_face_count. The receiver cannot stall; sample it then.
//   o_valid is registered behind the decode, read and output steps of a read.
//   Busy stays high through decode and load, or decode, read and output; the
//   next word can be taken at the first rising edge after busy drops.
//   A face holds busy through a normalizing shift of 0 to 35 steps, 7 multiply
//   steps for the cross product on one shared multiplier, 32 square root steps
//   and twelve 16-step divides (three for the unit normal, nine for the
//   averages); a zero cross product skips the square root and unit divides.
//   Reset: the normal/count memory is swept to zero, one entry per cycle, over
//   all VERTEX_DEPTH entries; busy stays high until the sweep is done.
//   Positions are undefined until loaded.
// ----------------------------------------------------------------------------
module vertex_normal_averager_top #(
    parameter int VERTEX_DEPTH = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_action,
    input  logic [9:0]         i_vertex_index,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic [9:0]         i_corner_a,
    input  logic [9:0]         i_corner_b,
    input  logic [9:0]         i_corner_c,
    output logic               o_valid,
    output logic signed [15:0] o_norm_x,
    output logic signed [15:0] o_norm_y,
    output logic signed [15:0] o_norm_z,
    output logic [15:0]        o_face_count
);
    import vna_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic     take;

    // Take a word only when the sequencer is idle
    assign take = start && !busy;

    vna_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    vna_dp #(
        .VERTEX_DEPTH (VERTEX_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_take         (take),
        .i_action       (i_action),
        .i_vertex_index (i_vertex_index),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_pos_z        (i_pos_z),
        .i_corner_a     (i_corner_a),
        .i_corner_b     (i_corner_b),
        .i_corner_c     (i_corner_c),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_valid        (o_valid),
        .o_norm_x       (o_norm_x),
        .o_norm_y       (o_norm_y),
        .o_norm_z       (o_norm_z),
        .o_face_count   (o_face_count)
    );

endmodule

@@ rtl/core/vna_checker.sv @@
// ----------------------------------------------------------------------------
// vna_checker
// Port-level checks of the vertex normal averager, bound to the top level.
// ----------------------------------------------------------------------------
module vna_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_valid,
    input logic signed [15:0] o_norm_x,
    input logic signed [15:0] o_norm_y,
    input logic signed [15:0] o_norm_z
);

    // The memory sweep after reset keeps the block busy
    a_busy_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("busy low right after reset");

    // An accepted word holds off the next one
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy low after accepting a word");

    // Result strobe lasts a single cycle
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held");

    // Averaged components stay within unit range
    a_norm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_norm_x >= -16'sd16384 && o_norm_x <= 16'sd16384 &&
                     o_norm_y >= -16'sd16384 && o_norm_y <= 16'sd16384 &&
                     o_norm_z >= -16'sd16384 && o_norm_z <= 16'sd16384))
        else $error("normal component out of range");

endmodule

bind vertex_normal_averager_top vna_checker u_vna_checker (.*);
